// ===== hw/rtl/bpms_pkg.sv =====
// Shared types, codes and helpers for the board power monitor sequencer.
// Used by bpms_tick and board_power_monitor_sequencer; no dependencies.
package bpms_pkg;

   // command codes
   localparam logic [2:0] CMD_POWER_ON  = 3'd0;
   localparam logic [2:0] CMD_POWER_OFF = 3'd1;
   localparam logic [2:0] CMD_RESET     = 3'd2;
   localparam logic [2:0] CMD_FAN1      = 3'd3;
   localparam logic [2:0] CMD_FAN2      = 3'd4;
   localparam logic [2:0] CMD_FAN_AUTO  = 3'd5;

   // power actions
   localparam logic [1:0] PWR_NONE = 2'd0;
   localparam logic [1:0] PWR_ON   = 2'd1;
   localparam logic [1:0] PWR_OFF  = 2'd2;

   // fan actions
   localparam logic [1:0] FAN_NONE = 2'd0;
   localparam logic [1:0] FAN_ONE  = 2'd1;
   localparam logic [1:0] FAN_TWO  = 2'd2;
   localparam logic [1:0] FAN_AUTO = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_BLANK    = 2'd1;
   localparam logic [1:0] CSR_LED      = 2'd2;

   localparam logic [7:0]  DEBOUNCE_RST = 8'd3;
   localparam logic [15:0] BLANK_RST    = 16'd200;
   localparam logic [7:0]  LED_RST      = 8'd5;
   localparam logic [6:0]  DUTY_MAX     = 7'd100;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] startup_blank_ticks;
      logic [7:0]  led_toggle_ticks;
   } cfg_type;

   typedef struct packed {
      logic [15:0] blank_count;
      logic        blank_done;
      logic        accepted_level;
      logic [7:0]  mismatch_count;
      logic        power_flag;
      logic        trusted_flag;
      logic [7:0]  blink_count;
      logic        blink_phase;
      logic        led_level;
   } state_type;

   typedef struct packed {
      logic               feedback_level;
      logic               remote_reset_req;
      logic signed [15:0] duty_value;
      logic               duty_present;
      logic [2:0]         cmd_code;
      logic               cmd_valid;
   } item_type;

   // packed so bit 0 is power_action[0], matching rsp_tdata
   typedef struct packed {
      logic       monitoring_active;
      logic       state_trusted;
      logic       board_powered;
      logic       led_pin;
      logic       cmd_error;
      logic [6:0] fan_duty;
      logic [1:0] fan_action;
      logic [1:0] reset_pulses;
      logic [1:0] power_action;
   } result_type;

   function automatic logic [6:0] clamp_duty(input logic signed [15:0] duty);
      logic [6:0] res;
      if (duty[15]) begin
         res = 7'd0;
      end else if (duty > $signed({9'd0, DUTY_MAX})) begin
         res = DUTY_MAX;
      end else begin
         res = duty[6:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/board_power_monitor_sequencer.sv =====
// Board power monitor sequencer top level: stream ports, csr registers,
// input and result registers. Depends on bpms_pkg and bpms_tick.
//
// One req transfer is one 50 ms poll tick; each produces exactly one rsp
// transfer with the power/reset/fan actions and the status flags.
// rsp_tvalid rises once the tick has passed through the input register
// and been written to the result register; a held result keeps the tick
// waiting in the input register. Throughput is one tick per cycle while
// rsp_tready is high; the debounce, blanking and blink state is updated
// in the same cycle in which a tick moves from the input register to the
// result register.
// The csr port writes debounce_ticks (0), startup_blank_ticks (1) and
// led_toggle_ticks (2); write only while no tick is in flight.
// Reset (synchronous) restores the csr defaults (3, 200, 5), clears both
// registers and returns the monitor to the blanking phase, LED pin high.
// When rsp_tready is low the result holds, the input register still
// fills, and req_tready drops once both are occupied.
module board_power_monitor_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] duty_present, [16:1] duty_value, [17] remote_reset_req,
   // [18] feedback_level, [23:19] zero
   input  logic [23:0] req_tdata,
   // [0] cmd_valid, [3:1] cmd_code
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] power_action, [3:2] reset_pulses, [5:4] fan_action,
   // [12:6] fan_duty, [13] cmd_error, [14] led_pin, [15] board_powered,
   // [16] state_trusted, [17] monitoring_active, [23:18] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bpms_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  st_ff;
   state_type  st_in;
   state_type  st_nxt;
   item_type   item_ff;
   item_type   item_in;
   result_type res_ff;
   result_type res_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, res_ff};

   assign item_in = '{
      feedback_level:   req_tdata[18],
      remote_reset_req: req_tdata[17],
      duty_value:       req_tdata[16:1],
      duty_present:     req_tdata[0],
      cmd_code:         req_tuser[3:1],
      cmd_valid:        req_tuser[0]
   };

   bpms_tick u_tick (
      .cfg  (cfg_ff),
      .cur  (st_ff),
      .item (item_ff),
      .nxt  (st_nxt),
      .res  (res_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks      = csr_wdata[7:0];
            CSR_BLANK:    cfg_in.startup_blank_ticks = csr_wdata;
            CSR_LED:      cfg_in.led_toggle_ticks    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign st_in        = advance ? st_nxt : st_ff;
   assign in_valid_in  = req_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{debounce_ticks: DEBOUNCE_RST, startup_blank_ticks: BLANK_RST,
                           led_toggle_ticks: LED_RST};
         st_ff        <= '{blank_count: 16'd0, blank_done: 1'b0, accepted_level: 1'b1,
                           mismatch_count: 8'd0, power_flag: 1'b0, trusted_flag: 1'b0,
                           blink_count: 8'd0, blink_phase: 1'b0, led_level: 1'b1};
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         st_ff        <= st_in;
         in_valid_ff  <= req_tready ? in_valid_in : in_valid_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   // monitoring never turns off again once blanking ends
   a_blank_sticky: assert property (@(posedge clock) disable iff (reset)
      st_ff.blank_done |=> st_ff.blank_done)
      else $error("blanking restarted");

   a_blank_trusted: assert property (@(posedge clock) disable iff (reset)
      st_ff.blank_done |-> st_ff.trusted_flag)
      else $error("monitoring active but state not trusted");

   a_led_unpowered: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !res_ff.board_powered) |-> res_ff.led_pin)
      else $error("LED low while unpowered");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (res_ff.fan_duty <= DUTY_MAX))
      else $error("fan duty out of range");

   a_err_no_fan: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && res_ff.cmd_error) |-> (res_ff.fan_action == FAN_NONE))
      else $error("fan action with command error");

endmodule

// ===== hw/rtl/bpms_tick.sv =====
// Next-state and result logic for one poll tick: command decode, remote
// reset, blanking, feedback debounce and LED blink. Depends on bpms_pkg.
module bpms_tick (
   input  bpms_pkg::cfg_type    cfg,
   input  bpms_pkg::state_type  cur,
   input  bpms_pkg::item_type   item,
   output bpms_pkg::state_type  nxt,
   output bpms_pkg::result_type res
);
   import bpms_pkg::*;

   logic [15:0] blank_inc;
   logic [7:0]  mismatch_inc;
   logic [7:0]  blink_inc;
   logic [1:0]  power_action;
   logic [1:0]  pulses;
   logic [1:0]  fan_action;
   logic [6:0]  fan_duty;
   logic        err;

   assign blank_inc    = cur.blank_count + 16'd1;
   assign mismatch_inc = cur.mismatch_count + 8'd1;

   always_comb begin
      nxt          = cur;
      power_action = PWR_NONE;
      pulses       = 2'd0;
      fan_action   = FAN_NONE;
      fan_duty     = 7'd0;
      err          = 1'b0;
      blink_inc    = cur.blink_count + 8'd1;

      if (item.cmd_valid) begin
         case (item.cmd_code)
            CMD_POWER_ON: begin
               power_action     = PWR_ON;
               nxt.power_flag   = 1'b1;
               nxt.trusted_flag = 1'b1;
            end
            CMD_POWER_OFF: begin
               power_action     = PWR_OFF;
               nxt.power_flag   = 1'b0;
               nxt.trusted_flag = 1'b1;
            end
            CMD_RESET: pulses = 2'd1;
            CMD_FAN1, CMD_FAN2: begin
               if (item.duty_present) begin
                  fan_action = (item.cmd_code == CMD_FAN1) ? FAN_ONE : FAN_TWO;
                  fan_duty   = clamp_duty(item.duty_value);
               end else begin
                  err = 1'b1;
               end
            end
            CMD_FAN_AUTO: fan_action = FAN_AUTO;
            default: ;
         endcase
      end

      if (item.remote_reset_req) begin
         pulses = pulses + 2'd1;
      end

      // blanking tick never samples feedback
      if (!cur.blank_done) begin
         nxt.blank_count = blank_inc;
         if (blank_inc >= cfg.startup_blank_ticks) begin
            nxt.blank_done   = 1'b1;
            nxt.trusted_flag = 1'b1;
         end
      end else if (item.feedback_level != cur.accepted_level) begin
         nxt.mismatch_count = mismatch_inc;
         if (mismatch_inc >= cfg.debounce_ticks) begin
            nxt.accepted_level = item.feedback_level;
            nxt.mismatch_count = 8'd0;
            nxt.power_flag     = ~item.feedback_level;
            power_action       = item.feedback_level ? PWR_OFF : PWR_ON;
         end
      end else begin
         nxt.mismatch_count = 8'd0;
      end

      if (nxt.power_flag) begin
         nxt.blink_count = blink_inc;
         if (blink_inc >= cfg.led_toggle_ticks) begin
            nxt.blink_count = 8'd0;
            nxt.blink_phase = ~cur.blink_phase;
            nxt.led_level   = ~cur.blink_phase;
         end
      end else begin
         nxt.blink_count = 8'd0;
         nxt.blink_phase = 1'b0;
         nxt.led_level   = 1'b1;
      end

      res.power_action      = power_action;
      res.reset_pulses      = pulses;
      res.fan_action        = fan_action;
      res.fan_duty          = fan_duty;
      res.cmd_error         = err;
      res.led_pin           = nxt.led_level;
      res.board_powered     = nxt.power_flag;
      res.state_trusted     = nxt.trusted_flag;
      res.monitoring_active = nxt.blank_done;
   end

endmodule
